FILE: sv/nan_aware_horizon_blend_core_assert.svh
// assertion macros for the horizon blend core checker
// no dependencies; included by the checker file only
`ifndef NAN_AWARE_HORIZON_BLEND_CORE_ASSERT_SVH
`define NAN_AWARE_HORIZON_BLEND_CORE_ASSERT_SVH

// same-cycle implication
`define NAHB_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define NAHB_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// implication after a fixed number of cycles
`define NAHB_ASSERT_DLY(lbl, clk, rst_n, ante, n, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
        else $error(msg);

`endif

FILE: sv/nahb_pkg.sv
// shared types and constants for the horizon blend core
// no dependencies
package nahb_pkg;

    localparam int C_FRAC_BITS  = 16;
    localparam int C_W_BITS     = C_FRAC_BITS + 1;
    localparam int C_VAL_BITS   = 32;
    localparam int C_SUM_BITS   = 56;
    localparam int C_SEEN_BITS  = 24;
    localparam int C_PROD_BITS  = C_VAL_BITS + C_W_BITS + 1;
    localparam int C_RATE_BITS  = 17;
    localparam int C_DIV_STEPS  = C_VAL_BITS;
    localparam int C_CNT_BITS   = $clog2(C_DIV_STEPS);
    localparam int C_IDX_BITS   = 2;

    localparam logic [C_W_BITS-1:0] C_ONE = C_W_BITS'(1) << C_FRAC_BITS;

    // configuration register indexes
    localparam logic [C_IDX_BITS-1:0] C_REG_BLEND_MODE = C_IDX_BITS'(0);
    localparam logic [C_IDX_BITS-1:0] C_REG_TRADE_RATE = C_IDX_BITS'(1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_ACC,
        S_DECAY,
        S_ABS,
        S_CHK,
        S_DIV,
        S_FIN
    } t_state;

    typedef struct packed {
        logic load;
        logic mul_decay;
        logic acc_en;
        logic decay_en;
        logic abs_en;
        logic chk_en;
        logic div_step;
        logic fin_en;
    } t_dp_ctrl;

    typedef struct packed {
        logic last_h;
        logic out_full;
    } t_dp_stat;

endpackage

FILE: sv/nahb_dp.sv
// datapath: config registers, shared multiplier, accumulators, radix-2 divider
// and output register; depends on nahb_pkg
module nahb_dp (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  nahb_pkg::t_dp_ctrl                       i_ctrl,
    output nahb_pkg::t_dp_stat                       o_stat,
    input  logic                                     i_cfg_we,
    input  logic [nahb_pkg::C_IDX_BITS-1:0]          i_cfg_index,
    input  logic [nahb_pkg::C_RATE_BITS-1:0]         i_cfg_data,
    input  logic signed [nahb_pkg::C_VAL_BITS-1:0]   i_sample_value,
    input  logic                                     i_sample_valid,
    input  logic                                     i_last_horizon,
    input  logic                                     i_last_name,
    input  logic                                     i_out_stall,
    output logic                                     o_out_valid,
    output logic signed [nahb_pkg::C_VAL_BITS-1:0]   o_aim_value,
    output logic                                     o_aim_valid,
    output logic                                     o_period_end
);
    import nahb_pkg::*;

    localparam logic signed [C_SUM_BITS-1:0] C_SUM_MAX = {1'b0, {(C_SUM_BITS-1){1'b1}}};
    localparam logic signed [C_SUM_BITS-1:0] C_SUM_MIN = {1'b1, {(C_SUM_BITS-1){1'b0}}};
    localparam logic signed [C_VAL_BITS-1:0] C_VAL_MAX = {1'b0, {(C_VAL_BITS-1){1'b1}}};
    localparam logic signed [C_VAL_BITS-1:0] C_VAL_MIN = {1'b1, {(C_VAL_BITS-1){1'b0}}};
    localparam logic [C_VAL_BITS-1:0]        C_MAG_MIN = {1'b1, {(C_VAL_BITS-1){1'b0}}};

    logic                          r_mode;
    logic [C_RATE_BITS-1:0]        r_rate;

    logic signed [C_VAL_BITS-1:0]  r_v;
    logic                          r_valid;
    logic                          r_last_h;
    logic                          r_last_n;
    logic [C_W_BITS-1:0]           r_w;

    logic signed [C_SUM_BITS-1:0]  r_ws;
    logic [C_SEEN_BITS-1:0]        r_seen;
    logic [C_W_BITS-1:0]           r_cw;

    logic signed [C_PROD_BITS-1:0] r_prod;

    logic [C_SEEN_BITS-1:0]        r_rem;
    logic [C_VAL_BITS-1:0]         r_quo;
    logic                          r_neg;
    logic                          r_ovf;

    logic                          r_out_valid;
    logic signed [C_VAL_BITS-1:0]  r_aim_value;
    logic                          r_aim_valid;
    logic                          r_period_end;

    logic [C_W_BITS-1:0]           rate_sat;
    logic [C_W_BITS-1:0]           factor;
    logic signed [C_W_BITS:0]      mul_a;
    logic signed [C_VAL_BITS:0]    mul_b;
    logic signed [C_PROD_BITS:0]   mul_full;
    logic signed [C_SUM_BITS:0]    sum_ext;
    logic [C_SEEN_BITS:0]          seen_ext;
    logic [C_SUM_BITS-1:0]         mag;
    logic [C_SEEN_BITS:0]          div_part;
    logic [C_SEEN_BITS:0]          div_diff;
    logic                          div_ge;
    logic signed [C_VAL_BITS-1:0]  res_value;
    logic                          res_valid;

    // decay factor, rate saturated at one
    assign rate_sat = (r_rate > C_RATE_BITS'(C_ONE)) ? C_ONE : C_W_BITS'(r_rate);
    assign factor   = C_ONE - rate_sat;

    // shared multiplier: weight times sample, then weight times decay factor
    assign mul_a    = $signed({1'b0, (i_ctrl.mul_decay ? r_cw : r_w)});
    assign mul_b    = i_ctrl.mul_decay ? $signed({{(C_VAL_BITS-C_W_BITS+1){1'b0}}, factor})
                                       : (C_VAL_BITS+1)'(r_v);
    assign mul_full = mul_a * mul_b;

    assign sum_ext  = (C_SUM_BITS+1)'(r_ws) + (C_SUM_BITS+1)'(r_prod);
    assign seen_ext = {1'b0, r_seen} + (C_SEEN_BITS+1)'(r_w);

    assign mag      = r_ws[C_SUM_BITS-1] ? unsigned'(-r_ws) : unsigned'(r_ws);

    // one restoring division step
    assign div_part = {r_rem, r_quo[C_VAL_BITS-1]};
    assign div_ge   = div_part >= {1'b0, r_seen};
    assign div_diff = div_part - {1'b0, r_seen};

    always_comb begin
        res_valid = (r_seen != '0);
        res_value = '0;
        if (res_valid) begin
            if (r_neg) begin
                if (r_ovf || (r_quo > C_MAG_MIN)) begin
                    res_value = C_VAL_MIN;
                end else begin
                    res_value = signed'(-r_quo);
                end
            end else begin
                if (r_ovf || r_quo[C_VAL_BITS-1]) begin
                    res_value = C_VAL_MAX;
                end else begin
                    res_value = signed'(r_quo);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_rate <= C_RATE_BITS'(C_ONE);
        end else if (i_cfg_we) begin
            if (i_cfg_index == C_REG_BLEND_MODE) begin
                r_mode <= i_cfg_data[0];
            end else if (i_cfg_index == C_REG_TRADE_RATE) begin
                r_rate <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_v      <= i_sample_value;
            r_valid  <= i_sample_valid;
            r_last_h <= i_last_horizon;
            r_last_n <= i_last_name;
            r_w      <= r_mode ? r_cw : C_ONE;
        end
        r_prod <= mul_full[C_PROD_BITS-1:0];
        if (i_ctrl.abs_en) begin
            r_rem <= mag[C_SUM_BITS-1:C_VAL_BITS];
            r_quo <= mag[C_VAL_BITS-1:0];
            r_neg <= r_ws[C_SUM_BITS-1];
        end else if (i_ctrl.div_step) begin
            r_rem <= div_ge ? div_diff[C_SEEN_BITS-1:0] : div_part[C_SEEN_BITS-1:0];
            r_quo <= {r_quo[C_VAL_BITS-2:0], div_ge};
        end
        if (i_ctrl.chk_en) begin
            r_ovf <= (r_rem >= r_seen);
        end
    end

    // per-name state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ws   <= '0;
            r_seen <= '0;
            r_cw   <= C_ONE;
        end else if (i_ctrl.fin_en) begin
            r_ws   <= '0;
            r_seen <= '0;
            r_cw   <= C_ONE;
        end else begin
            if (i_ctrl.acc_en && r_valid) begin
                if (sum_ext[C_SUM_BITS] != sum_ext[C_SUM_BITS-1]) begin
                    r_ws <= sum_ext[C_SUM_BITS] ? C_SUM_MIN : C_SUM_MAX;
                end else begin
                    r_ws <= sum_ext[C_SUM_BITS-1:0];
                end
                r_seen <= seen_ext[C_SEEN_BITS] ? '1 : seen_ext[C_SEEN_BITS-1:0];
            end
            if (i_ctrl.decay_en) begin
                r_cw <= r_prod[C_FRAC_BITS +: C_W_BITS];
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctrl.fin_en) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.fin_en) begin
            r_aim_value  <= res_value;
            r_aim_valid  <= res_valid;
            r_period_end <= r_last_n;
        end
    end

    assign o_stat.last_h   = r_last_h;
    assign o_stat.out_full = r_out_valid && i_out_stall;

    assign o_out_valid  = r_out_valid;
    assign o_aim_value  = r_aim_value;
    assign o_aim_valid  = r_aim_valid;
    assign o_period_end = r_period_end;

endmodule

FILE: sv/nahb_ctrl.sv
// sequencer: steps one request through multiply, accumulate, decay and, on a last-horizon row, divide
// depends on nahb_pkg
module nahb_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  nahb_pkg::t_dp_stat i_stat,
    output nahb_pkg::t_dp_ctrl o_ctrl
);
    import nahb_pkg::*;

    t_state                r_state;
    t_state                n_state;
    logic [C_CNT_BITS-1:0] r_cnt;
    logic [C_CNT_BITS-1:0] n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_MUL;
            S_MUL:   n_state = S_ACC;
            S_ACC:   n_state = S_DECAY;
            S_DECAY: n_state = i_stat.last_h ? S_ABS : S_IDLE;
            S_ABS:   n_state = S_CHK;
            S_CHK: begin
                n_state = S_DIV;
                n_cnt   = C_CNT_BITS'(C_DIV_STEPS - 1);
            end
            S_DIV: begin
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) n_state = S_FIN;
            end
            S_FIN:   if (!i_stat.out_full) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ctrl = '0;
        case (r_state)
            S_IDLE:  o_ctrl.load      = i_in_valid;
            S_MUL:   o_ctrl.mul_decay = 1'b0;
            S_ACC: begin
                o_ctrl.acc_en    = 1'b1;
                o_ctrl.mul_decay = 1'b1;
            end
            S_DECAY: o_ctrl.decay_en  = 1'b1;
            S_ABS:   o_ctrl.abs_en    = 1'b1;
            S_CHK:   o_ctrl.chk_en    = 1'b1;
            S_DIV:   o_ctrl.div_step  = 1'b1;
            S_FIN:   o_ctrl.fin_en    = !i_stat.out_full;
            default: o_ctrl = '0;
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

FILE: sv/nan_aware_horizon_blend_core.sv
// top level of the horizon blend core: sequencer plus shared datapath
// depends on nahb_pkg, nahb_ctrl and nahb_dp
//
// usage
// - input channel (i_in_valid / o_in_stall): one request per horizon row of a
//   name, carrying a q16.16 sample, its valid flag and last-horizon/last-name marks
// - output channel (o_out_valid / i_out_stall): one blended aim per name, given
//   on the row marked last horizon; rows without the mark give nothing
// - config channel (i_cfg_valid / o_cfg_ready): index 0 blend mode, index 1 trade
//   rate; always ready, write only while the core is idle
// - a row without the last-horizon mark is loaded, multiplied, accumulated and
//   decayed through the one shared multiplier; no new row is taken meanwhile
// - a last-horizon row adds magnitude, range check, 32 steps of the
//   radix-2 divider, then the result is registered; result visible the
//   cycle after
// - the output register frees the input side: new rows are taken while a result
//   waits; only a second result stalls the sequencer until the first is taken
// - reset (synchronous, active low) clears the sequencer, the output valid, the
//   per-name sums and loads blend mode 0 and trade rate 1.0
module nan_aware_horizon_blend_core (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // input channel
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic signed [nahb_pkg::C_VAL_BITS-1:0] i_sample_value,
    input  logic                                   i_sample_valid,
    input  logic                                   i_last_horizon,
    input  logic                                   i_last_name,
    // output channel
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic signed [nahb_pkg::C_VAL_BITS-1:0] o_aim_value,
    output logic                                   o_aim_valid,
    output logic                                   o_period_end,
    // configuration channel
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [nahb_pkg::C_IDX_BITS-1:0]        i_cfg_index,
    input  logic [nahb_pkg::C_RATE_BITS-1:0]       i_cfg_data
);
    import nahb_pkg::*;

    t_dp_ctrl ctrl;
    t_dp_stat stat;
    logic     cfg_we;

    // register writes must not collide with work; the block does not enforce this and keeps the port always open
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    nahb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_ctrl     (ctrl)
    );

    nahb_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctrl         (ctrl),
        .o_stat         (stat),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_sample_value (i_sample_value),
        .i_sample_valid (i_sample_valid),
        .i_last_horizon (i_last_horizon),
        .i_last_name    (i_last_name),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_aim_value    (o_aim_value),
        .o_aim_valid    (o_aim_valid),
        .o_period_end   (o_period_end)
    );

endmodule

FILE: sv/nahb_chk.sv
// port-level checker for the horizon blend core, bound to the top level
// depends on nan_aware_horizon_blend_core_assert.svh and nahb_pkg
`include "nan_aware_horizon_blend_core_assert.svh"

module nahb_chk (
    input logic                                   i_clk,
    input logic                                   i_rst_n,
    input logic                                   i_in_valid,
    input logic                                   o_in_stall,
    input logic                                   i_last_horizon,
    input logic                                   o_out_valid,
    input logic                                   i_out_stall,
    input logic signed [nahb_pkg::C_VAL_BITS-1:0] o_aim_value,
    input logic                                   o_aim_valid,
    input logic                                   o_period_end
);
    import nahb_pkg::*;

    logic in_acc;
    logic out_hold;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_hold = o_out_valid && i_out_stall;

    // stalled result holds
    `NAHB_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, out_hold, o_out_valid && $stable(o_aim_value) && $stable(o_aim_valid) && $stable(o_period_end), "stalled result changed")

    // an accepted request keeps the sequencer busy next cycle
    `NAHB_ASSERT_NXT(a_busy_after_acc, i_clk, i_rst_n, in_acc, o_in_stall, "core ready right after a request")

    // a row without the last mark frees the core once multiply, accumulate and decay are done
    `NAHB_ASSERT_DLY(a_row_time, i_clk, i_rst_n, in_acc && !i_last_horizon, 4, !o_in_stall, "plain row took wrong time")

    // no opinion means zero value
    `NAHB_ASSERT_IMP(a_zero_invalid, i_clk, i_rst_n, o_out_valid && !o_aim_valid, o_aim_value == '0, "invalid aim not zero")

endmodule

bind nan_aware_horizon_blend_core nahb_chk u_chk (.*);

FILE: dv/horizon_blend_checker.sv
`timescale 1ns / 100ps
// checker for the horizon blend core: watches the row, aim and config channels,
// keeps its own blend model and compares every aim field by field
// depends on nahb_pkg
module horizon_blend_checker (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    input  logic                                   i_in_stall,
    input  logic signed [nahb_pkg::C_VAL_BITS-1:0] i_sample_value,
    input  logic                                   i_sample_valid,
    input  logic                                   i_last_horizon,
    input  logic                                   i_last_name,
    input  logic                                   i_out_valid,
    input  logic                                   i_out_stall,
    input  logic signed [nahb_pkg::C_VAL_BITS-1:0] i_aim_value,
    input  logic                                   i_aim_valid,
    input  logic                                   i_period_end,
    input  logic                                   i_cfg_valid,
    input  logic                                   i_cfg_ready,
    input  logic [nahb_pkg::C_IDX_BITS-1:0]        i_cfg_index,
    input  logic [nahb_pkg::C_RATE_BITS-1:0]       i_cfg_data,
    output int                                     o_fail_count,
    output int                                     o_pending,
    output int                                     o_aims_checked,
    output int                                     o_no_opinion
);
    import nahb_pkg::*;

    localparam longint ONE_W   = longint'(1) << C_FRAC_BITS;
    localparam longint SUM_HI  = (longint'(1) << (C_SUM_BITS - 1)) - 1;
    localparam longint SUM_LO  = -(longint'(1) << (C_SUM_BITS - 1));
    localparam longint SEEN_HI = (longint'(1) << C_SEEN_BITS) - 1;
    localparam longint AIM_HI  = (longint'(1) << (C_VAL_BITS - 1)) - 1;
    localparam longint AIM_LO  = -(longint'(1) << (C_VAL_BITS - 1));

    typedef struct packed {
        logic signed [C_VAL_BITS-1:0] value;
        logic                         valid;
        logic                         period_end;
    } t_blended_aim;

    t_blended_aim aims_due[$];

    logic                   geo_mode;
    logic [C_RATE_BITS-1:0] rate_reg;
    longint                 weighted_acc;
    longint                 seen_acc;
    longint                 row_weight;
    bit                     seen_any;
    int                     fails;
    int                     checked;
    int                     no_opinion;

    initial begin
        fails      = 0;
        checked    = 0;
        no_opinion = 0;
    end

    function automatic void clear_name_state();
        weighted_acc = 0;
        seen_acc     = 0;
        row_weight   = ONE_W;
        seen_any     = 1'b0;
    endfunction

    // fold one row into the per-name sums; returns 1 when the row closes a name
    function automatic bit fold_row(input logic signed [C_VAL_BITS-1:0] value,
                                    input logic valid, input logic last_h,
                                    input logic last_n, output t_blended_aim aim);
        longint w;
        longint r;
        longint q;
        w = geo_mode ? row_weight : ONE_W;
        r = longint'(rate_reg);
        if (r > ONE_W)
            r = ONE_W;
        if (valid) begin
            weighted_acc = weighted_acc + w * longint'(value);
            if (weighted_acc > SUM_HI)
                weighted_acc = SUM_HI;
            if (weighted_acc < SUM_LO)
                weighted_acc = SUM_LO;
            seen_acc = seen_acc + w;
            if (seen_acc > SEEN_HI)
                seen_acc = SEEN_HI;
            seen_any = 1'b1;
        end
        row_weight = (row_weight * (ONE_W - r)) >> C_FRAC_BITS;
        aim = '0;
        if (!last_h)
            return 1'b0;
        if (seen_any && seen_acc > 0) begin
            q = weighted_acc / seen_acc;
            if (q > AIM_HI)
                q = AIM_HI;
            if (q < AIM_LO)
                q = AIM_LO;
            aim.value = C_VAL_BITS'(q);
            aim.valid = 1'b1;
        end
        aim.period_end = last_n;
        clear_name_state();
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin : watch
        t_blended_aim got;
        t_blended_aim want;
        if (!i_rst_n) begin
            geo_mode = 1'b0;
            rate_reg = C_ONE;
            clear_name_state();
            aims_due.delete();
        end else begin
            // aims first: an aim taken at this edge belongs to an earlier row
            if (i_out_valid && !i_out_stall) begin
                got = '{value: i_aim_value, valid: i_aim_valid, period_end: i_period_end};
                if (aims_due.size() == 0) begin
                    fails++;
                    $error("aim with none due: value %0d valid %0b period_end %0b",
                           got.value, got.valid, got.period_end);
                end else begin
                    want = aims_due.pop_front();
                    checked++;
                    if (!want.valid)
                        no_opinion++;
                    if (got.value !== want.value) begin
                        fails++;
                        $error("aim_value: expected %0d, got %0d", want.value, got.value);
                    end
                    if (got.valid !== want.valid) begin
                        fails++;
                        $error("aim_valid: expected %0b, got %0b", want.valid, got.valid);
                    end
                    if (got.period_end !== want.period_end) begin
                        fails++;
                        $error("period_end: expected %0b, got %0b",
                               want.period_end, got.period_end);
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    C_REG_BLEND_MODE: geo_mode = i_cfg_data[0];
                    C_REG_TRADE_RATE: rate_reg = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                if (fold_row(i_sample_value, i_sample_valid, i_last_horizon, i_last_name, want))
                    aims_due.insert(aims_due.size(), want);
            end
        end
        o_pending      <= aims_due.size();
        o_fail_count   <= fails;
        o_aims_checked <= checked;
        o_no_opinion   <= no_opinion;
    end

endmodule

FILE: dv/nan_aware_horizon_blend_core_test.sv
`timescale 1ns / 100ps
// top of the horizon blend core testbench: clock, reset, row and config stimulus
// and the verdict; depends on nahb_pkg, the core and horizon_blend_checker
module nan_aware_horizon_blend_core_test;
    import nahb_pkg::*;

    localparam int ROW_TARGET   = 1500;
    // longest legal stretch without any handshake stays well under this limit
    localparam int QUIET_LIMIT  = 4000;
    // pause after the last aim, for a last-horizon row plus the output register
    localparam int DRAIN_CYCLES = 60;
    // index with no register behind it, writes to it must be ignored
    localparam logic [C_IDX_BITS-1:0] REG_SPARE = C_IDX_BITS'(2);
    localparam logic signed [C_VAL_BITS-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [C_VAL_BITS-1:0] VAL_MIN = 32'sh8000_0000;

    typedef enum int {FILL_FULL, FILL_NARROW, FILL_MAX, FILL_MIN} t_fill;

    logic                         i_clk          = 1'b0;
    logic                         i_rst_n        = 1'b0;
    logic                         i_in_valid     = 1'b0;
    logic                         o_in_stall;
    logic signed [C_VAL_BITS-1:0] i_sample_value = '0;
    logic                         i_sample_valid = 1'b0;
    logic                         i_last_horizon = 1'b0;
    logic                         i_last_name    = 1'b0;
    logic                         o_out_valid;
    logic                         i_out_stall    = 1'b0;
    logic signed [C_VAL_BITS-1:0] o_aim_value;
    logic                         o_aim_valid;
    logic                         o_period_end;
    logic                         i_cfg_valid    = 1'b0;
    logic                         o_cfg_ready;
    logic [C_IDX_BITS-1:0]        i_cfg_index    = '0;
    logic [C_RATE_BITS-1:0]       i_cfg_data     = '0;

    int fail_count;
    int aims_pending;
    int aims_checked;
    int aims_no_opinion;

    // idling control, shared by the request and aim sides
    bit idle_on   = 1'b0;
    int gap_pct   = 0;
    int stall_pct = 0;
    int stall_left = 0;

    int rows_sent = 0;
    int settings  = 0;
    int quiet     = 0;

    nan_aware_horizon_blend_core uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_sample_value (i_sample_value),
        .i_sample_valid (i_sample_valid),
        .i_last_horizon (i_last_horizon),
        .i_last_name    (i_last_name),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_aim_value    (o_aim_value),
        .o_aim_valid    (o_aim_valid),
        .o_period_end   (o_period_end),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    horizon_blend_checker chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_sample_value (i_sample_value),
        .i_sample_valid (i_sample_valid),
        .i_last_horizon (i_last_horizon),
        .i_last_name    (i_last_name),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_aim_value    (o_aim_value),
        .i_aim_valid    (o_aim_valid),
        .i_period_end   (o_period_end),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (aims_pending),
        .o_aims_checked (aims_checked),
        .o_no_opinion   (aims_no_opinion)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // aim side back-pressure: stall bursts of random length, started at random
    always @(negedge i_clk) begin
        if (!idle_on)
            stall_left = 0;
        else if (stall_left > 0)
            stall_left--;
        else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
            stall_left = $urandom_range(1, 17);
        i_out_stall <= (stall_left > 0);
    end

    // watchdog: ends the run if no channel moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    // one horizon row request, with an optional gap in front of it
    task automatic send_row(input logic signed [C_VAL_BITS-1:0] value, input logic valid,
                            input logic last_h, input logic last_n);
        @(negedge i_clk);
        if (idle_on && gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_sample_value <= value;
        i_sample_valid <= valid;
        i_last_horizon <= last_h;
        i_last_name    <= last_n;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        rows_sent++;
    endtask

    task automatic write_reg(input logic [C_IDX_BITS-1:0] index,
                             input logic [C_RATE_BITS-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // drop the request, wait for every aim due and let the sequencer wind down
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (aims_pending != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic apply_setting(input logic geo, input logic [C_RATE_BITS-1:0] rate,
                                 input bit with_spare);
        logic [C_RATE_BITS-1:0] mode_word;
        settle();
        // upper bits of the mode word are noise, only bit 0 counts
        mode_word    = C_RATE_BITS'($urandom);
        mode_word[0] = geo;
        write_reg(C_REG_BLEND_MODE, mode_word);
        write_reg(C_REG_TRADE_RATE, rate);
        if (with_spare)
            write_reg(REG_SPARE, C_RATE_BITS'($urandom));
        settings++;
    endtask

    // one name: a run of rows closed by a last-horizon row
    task automatic send_name(input int rows, input t_fill fill, input int valid_pct);
        logic signed [C_VAL_BITS-1:0] v;
        logic [31:0]                  r;
        logic                         closing;
        for (int k = 0; k < rows; k++) begin
            r = $urandom;
            case (fill)
                FILL_NARROW: v = {{(C_VAL_BITS - 20){r[19]}}, r[19:0]};
                FILL_MAX:    v = VAL_MAX;
                FILL_MIN:    v = VAL_MIN;
                default:     v = r;
            endcase
            closing = (k == rows - 1);
            // stray last-name marks on inner rows must be ignored
            send_row(v, $urandom_range(0, 99) < valid_pct, closing,
                     closing ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 7) == 0));
        end
    endtask

    task automatic random_name();
        int    p;
        int    rows;
        int    vpct;
        t_fill fill;
        p = $urandom_range(0, 99);
        if (p < 3)
            rows = $urandom_range(257, 300);      // far past the horizon budget
        else if (p < 28)
            rows = $urandom_range(9, 72);
        else
            rows = $urandom_range(1, 8);
        case ($urandom_range(0, 9))
            0, 1:    fill = FILL_NARROW;
            2:       fill = FILL_MAX;
            3:       fill = FILL_MIN;
            default: fill = FILL_FULL;
        endcase
        p = $urandom_range(0, 19);
        vpct = (p == 0) ? 0 : (p < 5) ? 40 : (p < 12) ? 85 : 100;
        send_name(rows, fill, vpct);
    endtask

    initial begin : stimulus
        logic [C_RATE_BITS-1:0] rate;
        logic                   geo;
        int                     random_goal;
        int                     names;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset settings, uniform weighting
        send_row(VAL_MAX, 1'b1, 1'b1, 1'b0);      // largest aim
        send_row(VAL_MIN, 1'b1, 1'b1, 1'b1);      // smallest aim, period end
        send_row($urandom, 1'b0, 1'b1, 1'b0);     // nothing valid, no opinion
        send_row(32'sd5, 1'b1, 1'b0, 1'b1);       // last name without last horizon
        send_row(-32'sd8, 1'b1, 1'b1, 1'b0);      // negative mean rounds toward zero
        send_row(-32'sd1, 1'b1, 1'b0, 1'b0);
        send_row(32'sd0, 1'b0, 1'b0, 1'b0);
        send_row(32'sd0, 1'b1, 1'b1, 1'b1);

        // full trade rate: the weight drops to zero after the first row
        apply_setting(1'b1, C_ONE, 1'b1);
        send_row(32'sd0, 1'b0, 1'b0, 1'b0);       // valid only at zero weight
        send_row(32'sd100, 1'b1, 1'b1, 1'b0);
        send_row(32'sd100, 1'b1, 1'b0, 1'b0);
        send_row(VAL_MAX, 1'b1, 1'b1, 1'b0);

        // zero trade rate: no decay at all
        apply_setting(1'b1, '0, 1'b0);
        send_row(VAL_MAX, 1'b1, 1'b0, 1'b0);
        send_row(VAL_MIN, 1'b1, 1'b1, 1'b1);

        // trade rate above one saturates to one
        apply_setting(1'b1, '1, 1'b0);
        send_row(32'sd7, 1'b1, 1'b0, 1'b0);
        send_row(32'sd9, 1'b1, 1'b1, 1'b0);

        // half rate: weights 1, 1/2, 1/4
        apply_setting(1'b1, C_RATE_BITS'(32768), 1'b0);
        send_row(32'sd1000, 1'b1, 1'b0, 1'b0);
        send_row(32'sd2000, 1'b1, 1'b0, 1'b0);
        send_row(-32'sd4000, 1'b1, 1'b1, 1'b1);

        // random part, opened by saturating sums in uniform mode
        random_goal = rows_sent + ROW_TARGET;
        idle_on   = 1'b1;
        gap_pct   = 20;
        stall_pct = 10;
        apply_setting(1'b0, C_RATE_BITS'(1), 1'b0);
        send_name($urandom_range(257, 300), FILL_MAX, 100);
        send_name($urandom_range(257, 300), FILL_MIN, 100);

        while (rows_sent < random_goal) begin
            case ($urandom_range(0, 2))
                0:       gap_pct = 0;
                1:       gap_pct = 10;
                default: gap_pct = 40;
            endcase
            case ($urandom_range(0, 2))
                0:       stall_pct = 0;
                1:       stall_pct = 8;
                default: stall_pct = 30;
            endcase
            case ($urandom_range(0, 9))
                0:       rate = '0;
                1:       rate = C_RATE_BITS'(1);
                2:       rate = C_ONE - 1'b1;
                3:       rate = C_ONE;
                4:       rate = C_ONE + 1'b1;
                5:       rate = '1;
                6, 7:    rate = C_RATE_BITS'($urandom_range(1, 65536));
                default: rate = C_RATE_BITS'($urandom_range(0, 131071));
            endcase
            geo = ($urandom_range(0, 3) != 0);
            apply_setting(geo, rate, $urandom_range(0, 3) == 0);
            names = $urandom_range(10, 40);
            while (names > 0 && rows_sent < random_goal) begin
                // the closing stretch runs without idling
                idle_on = (rows_sent < random_goal - ROW_TARGET / 3);
                random_name();
                names--;
            end
        end

        settle();
        $display("covered %0d horizon rows under %0d register settings, with random gaps",
                 rows_sent, settings + 1);
        $display("and stalls; checked %0d aims, %0d of them with no opinion",
                 aims_checked, aims_no_opinion);
        if (fail_count == 0 && aims_pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+sv
sv/nahb_pkg.sv
sv/nahb_dp.sv
sv/nahb_ctrl.sv
sv/nan_aware_horizon_blend_core.sv
sv/nahb_chk.sv
dv/horizon_blend_checker.sv
dv/nan_aware_horizon_blend_core_test.sv
